>>> src/tpdp_pkg.sv
package tpdp_pkg;

    // Item fields
    localparam int LANES    = 4;
    localparam int ACT_W    = 8;
    localparam int CODE_W   = 2;
    localparam int WB_W     = LANES * CODE_W;
    localparam int CNT_W    = 3;
    localparam int RS_W     = 15;

    // Datapath widths
    localparam int LSUM_W   = 11;
    localparam int ACC_W    = 23;
    localparam int DOT_W    = 22;
    localparam int SCALE_W  = 32;
    localparam int SCALED_W = 38;
    localparam int FRAC_W   = 16;
    localparam int PROD_W   = DOT_W + SCALE_W + 1;
    localparam int OFFSET_SHIFT = 7;

    // Saturation limits
    localparam logic signed [ACC_W:0] ACC_MAX = 24'sd4194303;
    localparam logic signed [ACC_W:0] ACC_MIN = -24'sd4194304;
    localparam logic signed [ACC_W:0] DOT_MAX = 24'sd2097151;
    localparam logic signed [ACC_W:0] DOT_MIN = -24'sd2097152;

    // Scale register reset: 1.0 in Q16.16
    localparam logic [SCALE_W-1:0] SCALE_RESET = 32'h0001_0000;

    // Ternary weight codes
    localparam logic [CODE_W-1:0] CODE_POS = 2'd1;
    localparam logic [CODE_W-1:0] CODE_NEG = 2'd3;

    typedef logic [LANES-1:0][ACT_W-1:0] t_act_vec;

    // Row total handed from the accumulator to the scaler
    typedef struct packed {
        logic signed [ACC_W-1:0] acc;
        logic signed [RS_W-1:0]  row_sum;
    } t_row_total;

    // Sum activation times weight over the leading valid lanes
    function automatic logic signed [LSUM_W-1:0] lane_sum(
        input logic [WB_W-1:0]  wb,
        input t_act_vec         acts,
        input logic [CNT_W-1:0] cnt
    );
        logic signed [LSUM_W-1:0] sum;
        logic signed [LSUM_W-1:0] act_ext;
        logic [CODE_W-1:0]        code;
        sum = '0;
        for (int l = 0; l < LANES; l++) begin
            code    = wb[WB_W-1-CODE_W*l -: CODE_W];
            act_ext = $signed({{(LSUM_W-ACT_W){1'b0}}, acts[l]});
            if (CNT_W'(l) < cnt) begin
                if (code == CODE_POS) begin
                    sum = sum + act_ext;
                end else if (code == CODE_NEG) begin
                    sum = sum - act_ext;
                end
            end
        end
        return sum;
    endfunction

endpackage

>>> src/tpdp_accum.sv
module tpdp_accum (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [tpdp_pkg::WB_W-1:0]    i_weight_byte,
    input  tpdp_pkg::t_act_vec           i_acts,
    input  logic [tpdp_pkg::CNT_W-1:0]   i_valid_count,
    input  logic                         i_last_of_row,
    input  logic [tpdp_pkg::RS_W-1:0]    i_row_sum,
    output logic                         o_valid,
    input  logic                         i_ready,
    output tpdp_pkg::t_row_total         o_total
);
    import tpdp_pkg::*;

    logic                     r_a_valid;
    logic [WB_W-1:0]          r_a_wb;
    t_act_vec                 r_a_acts;
    logic [CNT_W-1:0]         r_a_cnt;
    logic                     r_a_last;
    logic [RS_W-1:0]          r_a_rs;

    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  n_acc;
    logic signed [ACC_W:0]    acc_wide;

    logic                     r_b_valid;
    t_row_total               r_b_total;

    logic                     b_ready;
    logic                     a_leave;
    logic                     a_fire;

    // Stage handshakes: non-last requests never wait on the output side
    assign b_ready = !r_b_valid || i_ready;
    assign a_leave = !r_a_last || b_ready;
    assign a_fire  = r_a_valid && a_leave;
    assign o_ready = !r_a_valid || a_leave;

    // Add this request's lanes into the running sum, saturating
    always_comb begin
        acc_wide = (ACC_W+1)'(r_acc) + (ACC_W+1)'(lane_sum(r_a_wb, r_a_acts, r_a_cnt));
        if (acc_wide > ACC_MAX) begin
            n_acc = ACC_MAX[ACC_W-1:0];
        end else if (acc_wide < ACC_MIN) begin
            n_acc = ACC_MIN[ACC_W-1:0];
        end else begin
            n_acc = acc_wide[ACC_W-1:0];
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (o_ready) begin
            r_a_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_a_wb   <= i_weight_byte;
            r_a_acts <= i_acts;
            r_a_cnt  <= i_valid_count;
            r_a_last <= i_last_of_row;
            r_a_rs   <= i_row_sum;
        end
    end

    // Accumulator: clear after the last request of a row
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (a_fire) begin
            r_acc <= r_a_last ? '0 : n_acc;
        end
    end

    // Row total register, loaded only by the last request of a row
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (a_fire && r_a_last) begin
            r_b_valid <= 1'b1;
        end else if (i_ready) begin
            r_b_valid <= 1'b0;
        end
        if (a_fire && r_a_last) begin
            r_b_total.acc     <= n_acc;
            r_b_total.row_sum <= $signed(r_a_rs);
        end
    end

    assign o_valid = r_b_valid;
    assign o_total = r_b_total;

endmodule

>>> src/tpdp_scale.sv
module tpdp_scale (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  tpdp_pkg::t_row_total           i_total,
    input  logic [tpdp_pkg::SCALE_W-1:0]   i_scale,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [tpdp_pkg::DOT_W-1:0]     o_corrected_dot,
    output logic [tpdp_pkg::SCALED_W-1:0]  o_scaled_value
);
    import tpdp_pkg::*;

    logic signed [ACC_W:0]    diff;
    logic signed [DOT_W-1:0]  n_dot;
    logic signed [PROD_W-1:0] n_prod;

    logic                     r_c_valid;
    logic signed [DOT_W-1:0]  r_c_dot;
    logic                     r_d_valid;
    logic signed [DOT_W-1:0]  r_d_dot;
    logic signed [PROD_W-1:0] r_d_prod;

    logic                     d_ready;

    assign d_ready = !r_d_valid || i_ready;
    assign o_ready = !r_c_valid || d_ready;

    // Remove the activation offset: raw - 128 * row_sum, saturated
    always_comb begin
        diff = (ACC_W+1)'(i_total.acc)
             - (ACC_W+1)'($signed({i_total.row_sum, {OFFSET_SHIFT{1'b0}}}));
        if (diff > DOT_MAX) begin
            n_dot = DOT_MAX[DOT_W-1:0];
        end else if (diff < DOT_MIN) begin
            n_dot = DOT_MIN[DOT_W-1:0];
        end else begin
            n_dot = diff[DOT_W-1:0];
        end
    end

    // Signed dot times unsigned scale
    assign n_prod = PROD_W'(r_c_dot) * $signed({1'b0, i_scale});

    // Corrected dot register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (o_ready) begin
            r_c_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_c_dot <= n_dot;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else if (d_ready) begin
            r_d_valid <= r_c_valid;
        end
        if (d_ready && r_c_valid) begin
            r_d_dot  <= r_c_dot;
            r_d_prod <= n_prod;
        end
    end

    // Arithmetic shift right by the fraction width
    assign o_valid         = r_d_valid;
    assign o_corrected_dot = r_d_dot;
    assign o_scaled_value  = r_d_prod[FRAC_W +: SCALED_W];

endmodule

>>> src/ternary_packed_dot_product.sv
// Ternary-weight dot product over packed 2-bit weights and offset-u8 activations. Each request
// carries one weight byte (lane 0 in bits 7:6) and four activations; the block accepts one
// request every cycle while a last-of-row request is not held back by a stalled output.
// Requests without last_of_row give no result. For the last request of a row a result
// (corrected_dot = raw - 128 * row_sum, and that value times output_scale in Q16.16, floored)
// passes in turn through the input, row total, corrected dot and result registers. The row
// total register lets in requests that are not last of a row while a result waits.
// Write output_scale only while no row result is pending.
module ternary_packed_dot_product (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [tpdp_pkg::SCALE_W-1:0]   i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [tpdp_pkg::WB_W-1:0]      i_weight_byte,
    input  logic [tpdp_pkg::ACT_W-1:0]     i_act_lane0,
    input  logic [tpdp_pkg::ACT_W-1:0]     i_act_lane1,
    input  logic [tpdp_pkg::ACT_W-1:0]     i_act_lane2,
    input  logic [tpdp_pkg::ACT_W-1:0]     i_act_lane3,
    input  logic [tpdp_pkg::CNT_W-1:0]     i_valid_count,
    input  logic                           i_last_of_row,
    input  logic [tpdp_pkg::RS_W-1:0]      i_row_sum,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [tpdp_pkg::DOT_W-1:0]     o_corrected_dot,
    output logic [tpdp_pkg::SCALED_W-1:0]  o_scaled_value
);
    import tpdp_pkg::*;

    logic [SCALE_W-1:0] r_output_scale;
    t_act_vec           acts;
    t_row_total         total;
    logic               total_valid;
    logic               total_ready;

    // Scale register, always ready for a write
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_output_scale <= SCALE_RESET;
        end else if (i_cfg_valid) begin
            r_output_scale <= i_cfg_data;
        end
    end

    assign acts = {i_act_lane3, i_act_lane2, i_act_lane1, i_act_lane0};

    tpdp_accum u_accum (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_weight_byte (i_weight_byte),
        .i_acts        (acts),
        .i_valid_count (i_valid_count),
        .i_last_of_row (i_last_of_row),
        .i_row_sum     (i_row_sum),
        .o_valid       (total_valid),
        .i_ready       (total_ready),
        .o_total       (total)
    );

    tpdp_scale u_scale (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (total_valid),
        .o_ready         (total_ready),
        .i_total         (total),
        .i_scale         (r_output_scale),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_corrected_dot (o_corrected_dot),
        .o_scaled_value  (o_scaled_value)
    );

endmodule

>>> src/tpdp_checker.sv
module tpdp_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           o_valid,
    input  logic                           i_ready,
    input  logic [tpdp_pkg::DOT_W-1:0]     o_corrected_dot,
    input  logic [tpdp_pkg::SCALED_W-1:0]  o_scaled_value
);
    import tpdp_pkg::*;

    // Hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_corrected_dot)
                                && $stable(o_scaled_value))
        else $error("result changed while stalled");

    // Drop all results on reset
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // Non-negative dot gives non-negative scaled value
    a_sign_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_corrected_dot[DOT_W-1] |-> !o_scaled_value[SCALED_W-1])
        else $error("scaled value negative for non-negative dot");

    // Negative dot gives negative or zero scaled value
    a_sign_neg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_corrected_dot[DOT_W-1]
            |-> o_scaled_value[SCALED_W-1] || (o_scaled_value == '0))
        else $error("scaled value positive for negative dot");

    // Zero dot gives zero scaled value
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_corrected_dot == '0) |-> (o_scaled_value == '0))
        else $error("scaled value nonzero for zero dot");

endmodule

bind ternary_packed_dot_product tpdp_checker u_tpdp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_corrected_dot (o_corrected_dot),
    .o_scaled_value  (o_scaled_value)
);
